### hdl/cor_pkg.sv
// ----------------------------------------------------------------------------
// cor_pkg
// shared types and constants of the circle outline rasterizer
// ----------------------------------------------------------------------------
package cor_pkg;

    // item operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // eight mirrored points per step, index bits select the mirror
    localparam int PTS_PER_STEP = 8;
    localparam int PT_IDX_W     = $clog2(PTS_PER_STEP);
    localparam logic [PT_IDX_W-1:0] PT_LAST = PT_IDX_W'(PTS_PER_STEP - 1);
    localparam int PT_SWAP_BIT  = 0;
    localparam int PT_NEGX_BIT  = 1;
    localparam int PT_NEGY_BIT  = 2;

    // step queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### hdl/circle_outline_rasterizer.sv
// ----------------------------------------------------------------------------
// circle_outline_rasterizer
// outline circle rasterizer, three-branch integer decision walk of one octant
// ----------------------------------------------------------------------------
// A start transaction (op 0) latches center and radius and produces nothing; each step
// transaction (op 1) yields the eight mirrored points of the current offsets, the eighth
// flagged last_in_step, all eight flagged circle_done on the closing step; a step with
// no circle running yields nothing. The front takes one transaction per cycle while its
// two-entry step queue has room. The back puts out one point per cycle while the output
// is not stalled and the queue holds a step; the first point of a step reaches the
// output through the step queue and then the output register.
module circle_outline_rasterizer #(
    parameter int COORD_WIDTH  = 16,
    parameter int RADIUS_WIDTH = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_op,
    input  logic signed [COORD_WIDTH-1:0]  i_center_x,
    input  logic signed [COORD_WIDTH-1:0]  i_center_y,
    input  logic [RADIUS_WIDTH-1:0]        i_radius,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [COORD_WIDTH:0]    o_point_x,
    output logic signed [COORD_WIDTH:0]    o_point_y,
    output logic                           o_last_in_step,
    output logic                           o_circle_done
);
    import cor_pkg::*;

    localparam int REC_W = 2 * COORD_WIDTH + 2 * (RADIUS_WIDTH + 2) + 1;

    t_q_stat          q_stat;
    logic             q_push;
    logic             q_pop;
    logic [REC_W-1:0] q_wdata;
    logic [REC_W-1:0] q_rdata;

    cor_front #(
        .CW (COORD_WIDTH),
        .RW (RADIUS_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_qstat    (q_stat),
        .o_push     (q_push),
        .o_rec      (q_wdata)
    );

    cor_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_stat  (q_stat)
    );

    cor_back #(
        .CW (COORD_WIDTH),
        .RW (RADIUS_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec          (q_rdata),
        .i_qstat        (q_stat),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_last_in_step (o_last_in_step),
        .o_circle_done  (o_circle_done)
    );

`ifndef SYNTHESIS
    // retiring a step must leave its eighth point in the output register
    a_pop_shows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_valid && o_last_in_step))
        else $error("step retired without its last point on the output");

    // front never writes a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("step pushed into a full queue");

    // back never reads an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("step popped from an empty queue");
`endif

endmodule

### hdl/cor_front.sv
// ----------------------------------------------------------------------------
// cor_front
// accepts start and step items, keeps the octant walk state and queues steps
// ----------------------------------------------------------------------------
module cor_front #(
    parameter int CW = 16,
    parameter int RW = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic signed [CW-1:0]          i_center_x,
    input  logic signed [CW-1:0]          i_center_y,
    input  logic [RW-1:0]                 i_radius,
    input  cor_pkg::t_q_stat              i_qstat,
    output logic                          o_push,
    output logic [2*CW+2*(RW+2):0]        o_rec
);
    import cor_pkg::*;

    localparam int OW = RW + 2;
    localparam int DW = RW + 4;
    localparam logic signed [DW-1:0] D_ONE = DW'(1);
    localparam logic signed [OW-1:0] O_ONE = OW'(1);

    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic [RW-1:0]        r_r;
    logic signed [OW-1:0] r_ox;
    logic signed [OW-1:0] r_oy;
    logic signed [DW-1:0] r_d;
    logic                 r_active;

    logic                 accept;
    logic                 emit;
    logic signed [DW-1:0] ox_d;
    logic signed [DW-1:0] oy_d;
    logic signed [DW-1:0] r_d_ext;
    logic signed [DW-1:0] twox;
    logic signed [DW-1:0] rmo2;
    logic signed [DW-1:0] n_d;
    logic signed [OW-1:0] n_ox;
    logic signed [OW-1:0] n_oy;
    logic                 done;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !o_stall;
    assign emit    = accept && (i_op == OP_STEP) && r_active && !(r_oy < r_ox);
    assign o_push  = emit;

    assign ox_d    = DW'(r_ox);
    assign oy_d    = DW'(r_oy);
    assign r_d_ext = DW'({1'b0, r_r});
    assign twox    = ox_d <<< 1;
    assign rmo2    = (r_d_ext - oy_d) <<< 1;

    // three-branch decision rule
    always_comb begin
        if (r_d >= twox) begin
            n_d  = r_d - twox - D_ONE;
            n_ox = r_ox + O_ONE;
            n_oy = r_oy;
        end else if (r_d < rmo2) begin
            n_d  = r_d + (oy_d <<< 1) - D_ONE;
            n_ox = r_ox;
            n_oy = r_oy - O_ONE;
        end else begin
            n_d  = r_d + ((oy_d - ox_d - D_ONE) <<< 1);
            n_ox = r_ox + O_ONE;
            n_oy = r_oy - O_ONE;
        end
    end

    assign done  = n_oy < n_ox;
    // queued step carries the offsets before the update
    assign o_rec = {r_cx, r_cy, r_ox, r_oy, done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (accept) begin
            if (i_op == OP_START) begin
                r_active <= 1'b1;
            end else if (!emit || done) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_op == OP_START)) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_r  <= i_radius;
            r_ox <= '0;
            r_oy <= OW'({1'b0, i_radius});
            r_d  <= DW'({1'b0, i_radius}) - D_ONE;
        end else if (emit) begin
            r_ox <= n_ox;
            r_oy <= n_oy;
            r_d  <= n_d;
        end
    end

endmodule

### hdl/cor_queue.sv
// ----------------------------------------------------------------------------
// cor_queue
// short fifo of pending steps between front and back
// ----------------------------------------------------------------------------
module cor_queue #(
    parameter int WIDTH = 61
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output cor_pkg::t_q_stat o_stat
);
    import cor_pkg::*;

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= Q_PTR_W'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= Q_PTR_W'(r_rd + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### hdl/cor_back.sv
// ----------------------------------------------------------------------------
// cor_back
// walks the eight mirrored points of the head step into the output register
// ----------------------------------------------------------------------------
module cor_back #(
    parameter int CW = 16,
    parameter int RW = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [2*CW+2*(RW+2):0]   i_rec,
    input  cor_pkg::t_q_stat         i_qstat,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [CW:0]       o_point_x,
    output logic signed [CW:0]       o_point_y,
    output logic                     o_last_in_step,
    output logic                     o_circle_done
);
    import cor_pkg::*;

    localparam int OW = RW + 2;
    localparam int SW = ((CW > OW) ? CW : OW) + 1;

    logic signed [CW-1:0] h_cx;
    logic signed [CW-1:0] h_cy;
    logic signed [OW-1:0] h_ox;
    logic signed [OW-1:0] h_oy;
    logic                 h_done;

    logic [PT_IDX_W-1:0]  r_idx;
    logic                 r_valid;
    logic                 load;
    logic signed [OW-1:0] dx;
    logic signed [OW-1:0] dy;
    logic signed [SW-1:0] px;
    logic signed [SW-1:0] py;

    assign {h_cx, h_cy, h_ox, h_oy, h_done} = i_rec;

    assign load  = (!r_valid || !i_stall) && !i_qstat.empty;
    assign o_pop = load && (r_idx == PT_LAST);

    // index bits pick swap of the offsets and the sign of each axis
    assign dx = r_idx[PT_SWAP_BIT] ? h_oy : h_ox;
    assign dy = r_idx[PT_SWAP_BIT] ? h_ox : h_oy;
    assign px = r_idx[PT_NEGX_BIT] ? (SW'(h_cx) - SW'(dx)) : (SW'(h_cx) + SW'(dx));
    assign py = r_idx[PT_NEGY_BIT] ? (SW'(h_cy) - SW'(dy)) : (SW'(h_cy) + SW'(dy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= PT_IDX_W'(r_idx + 1'b1);
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_point_x      <= px[CW:0];
            o_point_y      <= py[CW:0];
            o_last_in_step <= (r_idx == PT_LAST);
            o_circle_done  <= h_done;
        end
    end

    assign o_valid = r_valid;

endmodule

### bench/cor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_checker
// watches both channels of the circle outline rasterizer, walks the circle on
// its own and compares every emitted point with the oldest predicted one
// ----------------------------------------------------------------------------
module cor_checker #(
    parameter int COORD_WIDTH  = 16,
    parameter int RADIUS_WIDTH = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_op,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic [RADIUS_WIDTH-1:0]       i_radius,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [COORD_WIDTH:0]   i_point_x,
    input  logic signed [COORD_WIDTH:0]   i_point_y,
    input  logic                          i_last_in_step,
    input  logic                          i_circle_done,
    output int                            o_fail_count,
    output int                            o_points_owed
);
    import cor_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [COORD_WIDTH:0] x;
        logic signed [COORD_WIDTH:0] y;
        logic                        last;
        logic                        done;
    } t_pixel;

    t_pixel owed_pixels[$];

    // walk state of the circle being drawn
    int ctr_x     = 0;
    int ctr_y     = 0;
    int rad       = 0;
    int off_x     = 0;
    int off_y     = 0;
    int decision  = 0;
    bit drawing   = 1'b0;
    int fail_total = 0;

    task automatic walk_circle(input logic op, input logic signed [COORD_WIDTH-1:0] cx,
                               input logic signed [COORD_WIDTH-1:0] cy,
                               input logic [RADIUS_WIDTH-1:0] r);
        int     ox;
        int     oy;
        int     dx;
        int     dy;
        bit     done;
        t_pixel p;
        logic [PT_IDX_W-1:0] k;
        if (op == OP_START) begin
            ctr_x    = cx;
            ctr_y    = cy;
            rad      = r;
            off_x    = 0;
            off_y    = rad;
            decision = rad - 1;
            drawing  = 1'b1;
        end else if (!drawing || off_y < off_x) begin
            drawing = 1'b0;
        end else begin
            ox = off_x;
            oy = off_y;
            if (decision >= 2 * ox) begin
                decision = decision - (2 * ox + 1);
                off_x    = ox + 1;
            end else if (decision < 2 * (rad - oy)) begin
                decision = decision + 2 * oy - 1;
                off_y    = oy - 1;
            end else begin
                decision = decision + 2 * (oy - ox - 1);
                off_y    = oy - 1;
                off_x    = ox + 1;
            end
            done = off_y < off_x;
            if (done) drawing = 1'b0;
            // index bits pick swap, x mirror and y mirror
            for (int i = 0; i < PTS_PER_STEP; i++) begin
                k  = PT_IDX_W'(i);
                dx = k[PT_SWAP_BIT] ? oy : ox;
                dy = k[PT_SWAP_BIT] ? ox : oy;
                if (k[PT_NEGX_BIT]) dx = -dx;
                if (k[PT_NEGY_BIT]) dy = -dy;
                p.x    = (COORD_WIDTH + 1)'(ctr_x + dx);
                p.y    = (COORD_WIDTH + 1)'(ctr_y + dy);
                p.last = (k == PT_LAST);
                p.done = done;
                owed_pixels.push_back(p);
            end
        end
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (owed_pixels.size() == 0) begin
            fail_total++;
            if (fail_total <= MAX_REPORTS)
                $display("%0t: unexpected point x=%0d y=%0d last=%0b done=%0b",
                         $realtime, i_point_x, i_point_y, i_last_in_step, i_circle_done);
        end else begin
            want = owed_pixels.pop_front();
            if (want.x !== i_point_x || want.y !== i_point_y
                    || want.last !== i_last_in_step || want.done !== i_circle_done) begin
                fail_total++;
                if (fail_total <= MAX_REPORTS)
                    $display("%0t: point mismatch exp x=%0d y=%0d last=%0b done=%0b,",
                             $realtime, want.x, want.y, want.last, want.done,
                             " got x=%0d y=%0d last=%0b done=%0b",
                             i_point_x, i_point_y, i_last_in_step, i_circle_done);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) check_pixel();
            if (i_in_valid && !i_in_stall)
                walk_circle(i_op, i_center_x, i_center_y, i_radius);
        end
        o_fail_count  <= fail_total;
        o_points_owed <= owed_pixels.size();
    end

endmodule

### bench/tb_circle_outline_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_outline_rasterizer
// drives start and step transactions into the rasterizer under varying idle
// and stall pressure; the checker beside the block gives the failure count
// ----------------------------------------------------------------------------
module tb_circle_outline_rasterizer;
    import cor_pkg::*;

    localparam int CW           = 16;
    localparam int RW           = 12;
    localparam int RANDOM_ITEMS = 330;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 32;
    localparam int SMALL_RADIUS = 24;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 op        = OP_START;
    logic signed [CW-1:0] center_x  = '0;
    logic signed [CW-1:0] center_y  = '0;
    logic [RW-1:0]        radius    = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [CW:0]   point_x;
    logic signed [CW:0]   point_y;
    logic                 last_in_step;
    logic                 circle_done;
    int                   fail_count;
    int                   points_owed;
    int                   cycle_count   = 0;
    int                   send_idle_pct = 0;
    int                   stall_pct     = 0;
    int                   items_sent    = 0;

    circle_outline_rasterizer #(
        .COORD_WIDTH (CW),
        .RADIUS_WIDTH(RW)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_op          (op),
        .i_center_x    (center_x),
        .i_center_y    (center_y),
        .i_radius      (radius),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_point_x     (point_x),
        .o_point_y     (point_y),
        .o_last_in_step(last_in_step),
        .o_circle_done (circle_done)
    );

    cor_checker #(
        .COORD_WIDTH (CW),
        .RADIUS_WIDTH(RW)
    ) i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_op          (op),
        .i_center_x    (center_x),
        .i_center_y    (center_y),
        .i_radius      (radius),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_point_x     (point_x),
        .i_point_y     (point_y),
        .i_last_in_step(last_in_step),
        .i_circle_done (circle_done),
        .o_fail_count  (fail_count),
        .o_points_owed (points_owed)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // called and returns at a falling edge, valid left high for back-to-back items
    task automatic send_item(input logic o, input logic signed [CW-1:0] x,
                             input logic signed [CW-1:0] y, input logic [RW-1:0] r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        center_x <= x;
        center_y <= y;
        radius   <= r;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // step fields are ignored by the block, so they carry random junk
    task automatic send_steps(input int n);
        repeat (n) send_item(OP_STEP, CW'($urandom), CW'($urandom), RW'($urandom));
    endtask

    task automatic random_circle();
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [RW-1:0]        r;
        int                   kind;
        int                   n;
        x    = CW'($urandom);
        y    = CW'($urandom);
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // stray transaction with any opcode
            send_item(logic'($urandom_range(0, 1)), x, y, RW'($urandom));
            return;
        end
        if (kind == 1) begin
            x = $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            y = $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
        end
        if ($urandom_range(0, 7) == 0) r = RW'($urandom_range(0, (1 << RW) - 1));
        else r = RW'($urandom_range(0, SMALL_RADIUS));
        // big circles are cut short by the next start
        if (r > SMALL_RADIUS) n = $urandom_range(1, 6);
        else if (kind == 2) n = $urandom_range(0, r / 2);
        else n = (r * 7) / 8 + 2 + $urandom_range(0, 2);
        send_item(OP_START, x, y, r);
        send_steps(n);
    endtask

    initial begin
        int first_random;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // step with nothing running, then radius zero and one at the corners
        send_item(OP_STEP, '1, '1, '1);
        send_item(OP_START, 16'sh7fff, -16'sh8000, '0);
        send_steps(2);
        send_item(OP_START, -16'sh8000, 16'sh7fff, RW'(1));
        send_steps(3);
        // widest radius, abandoned by a new start while still running
        send_item(OP_START, '0, '0, '1);
        send_steps(3);
        send_item(OP_START, 16'sh7fff, 16'sh7fff, '1);
        send_steps(2);
        send_item(OP_START, -16'sh8000, -16'sh8000, RW'(5));
        send_steps(6);

        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            case (((items_sent - first_random) * 4) / RANDOM_ITEMS)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 61;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 61;
                end
                default: begin
                    send_idle_pct = 29;
                    stall_pct     = 29;
                end
            endcase
            random_circle();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (points_owed != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
hdl/cor_pkg.sv
hdl/cor_front.sv
hdl/cor_queue.sv
hdl/cor_back.sv
hdl/circle_outline_rasterizer.sv
bench/cor_checker.sv
bench/tb_circle_outline_rasterizer.sv
